// ===== rtl/sse_pkg.sv =====
// Shared constants, codes and controller/datapath signal types of the semaphore set engine.
`timescale 1ns / 1ps
`default_nettype none
package sse_pkg;

  localparam int NUM_SETS     = 32;
  localparam int SEMS_PER_SET = 32;
  localparam int SLOT_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int IDX_W        = (SEMS_PER_SET > 1) ? $clog2(SEMS_PER_SET) : 1;
  localparam int PCNT_W       = $clog2(SEMS_PER_SET + 1);
  localparam int ADDR_W       = SLOT_W + IDX_W;
  localparam int RAM_DEPTH    = NUM_SETS * (2 ** IDX_W);

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 6;
  localparam int ID_W     = 31;
  localparam int SIDX_W   = 6;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 3;

  localparam logic [ACTION_W-1:0] ACT_GET_SET   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SEM_OP    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_GET_VALUE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SET_VALUE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INDEX_BIG   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd6;
  localparam logic [STATUS_W-1:0] ST_MUST_WAIT   = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;
    logic                create_flag;
    logic                exclusive_flag;
    logic [ID_W-1:0]     set_id;
    logic [SIDX_W-1:0]   sem_index;
    logic [VAL_W-1:0]    sem_delta;
    logic                no_wait;
    logic                last_op;
    logic [VAL_W-1:0]    new_value;
  } item_t;

  typedef struct packed {
    logic                latch;
    logic                pend_push;
    logic                pend_clr;
    logic                scan_start;
    logic                scan_step;
    logic                op_clr;
    logic                op_inc;
    logic                zero_wr;
    logic                alloc;
    logic                remove;
    logic                rd_item;
    logic                rd_op;
    logic                wr_item;
    logic                wr_op;
    logic                val_clr;
    logic                val_ident;
    logic                val_ram;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_wake;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                key_nz;
    logic                create_flag;
    logic                exclusive_flag;
    logic                last_op;
    logic                cnt_over;
    logic                cnt_zero;
    logic                cnt_gt_size;
    logic                idx_bad;
    logic                scan_last;
    logic                match_found;
    logic                free_found;
    logic                pend_over;
    logic                pend_nowait;
    logic                op_done;
    logic                op_idx_bad;
    logic                chk_fail;
    logic                zero_last;
    logic                out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/sse_if.sv =====
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface sse_in_if;
  logic                          valid;
  logic                          ready;
  logic [sse_pkg::ACTION_W-1:0]  action;
  logic [sse_pkg::KEY_W-1:0]     key;
  logic [sse_pkg::COUNT_W-1:0]   count;
  logic                          create_flag;
  logic                          exclusive_flag;
  logic [sse_pkg::ID_W-1:0]      set_id;
  logic [sse_pkg::SIDX_W-1:0]    sem_index;
  logic signed [sse_pkg::VAL_W-1:0] sem_delta;
  logic                          no_wait;
  logic                          last_op;
  logic [sse_pkg::VAL_W-1:0]     new_value;
  modport source (output valid, action, key, count, create_flag, exclusive_flag, set_id,
                  sem_index, sem_delta, no_wait, last_op, new_value, input ready);
  modport sink (input valid, action, key, count, create_flag, exclusive_flag, set_id,
                sem_index, sem_delta, no_wait, last_op, new_value, output ready);
endinterface

interface sse_out_if;
  logic                          valid;
  logic                          ready;
  logic [sse_pkg::STATUS_W-1:0]  status;
  logic [sse_pkg::ID_W-1:0]      result_value;
  logic                          wake_waiters;
  modport source (output valid, status, result_value, wake_waiters, input ready);
  modport sink (input valid, status, result_value, wake_waiters, output ready);
endinterface
`default_nettype wire

// ===== rtl/sse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/sse_datapath.sv =====
// Datapath: slot table, operation buffer, counter memory and result register.
`timescale 1ns / 1ps
`default_nettype none
module sse_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sse_pkg::item_t                item_i,
  input  wire sse_pkg::cmd_t                 cmd_i,
  output sse_pkg::stat_t                     stat_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [sse_pkg::STATUS_W-1:0]       out_status_o,
  output logic [sse_pkg::ID_W-1:0]           out_value_o,
  output logic                               out_wake_o
);
  sse_pkg::item_t item_q;

  logic                          active_q [sse_pkg::NUM_SETS];
  logic [sse_pkg::KEY_W-1:0]     key_q    [sse_pkg::NUM_SETS];
  logic [sse_pkg::ID_W-1:0]      ident_q  [sse_pkg::NUM_SETS];
  logic [sse_pkg::COUNT_W-1:0]   size_q   [sse_pkg::NUM_SETS];
  logic [sse_pkg::ID_W-1:0]      next_ident_q;

  logic [sse_pkg::SLOT_W-1:0]    scan_q, mslot_q, fslot_q;
  logic                          mfound_q, ffound_q;
  logic [sse_pkg::COUNT_W-1:0]   msize_q;
  logic [sse_pkg::ID_W-1:0]      mident_q;

  logic [sse_pkg::SIDX_W+sse_pkg::VAL_W-1:0] pend_q [sse_pkg::SEMS_PER_SET];
  logic [sse_pkg::PCNT_W-1:0]    pend_cnt_q;
  logic                          pend_ovf_q, pend_nw_q;
  logic [sse_pkg::PCNT_W-1:0]    op_q;

  logic [sse_pkg::ID_W-1:0]      res_val_q;

  logic                          hit;
  logic [sse_pkg::SIDX_W+sse_pkg::VAL_W-1:0] op_entry;
  logic [sse_pkg::SIDX_W-1:0]    op_idx;
  logic [sse_pkg::VAL_W-1:0]     op_delta;
  logic [sse_pkg::VAL_W:0]       chk_sum;
  logic                          ram_we;
  logic [sse_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [sse_pkg::VAL_W-1:0]     ram_wdata, ram_rdata;
  logic [sse_pkg::ADDR_W-1:0]    item_addr, op_addr;

  assign op_entry = pend_q[op_q[sse_pkg::IDX_W-1:0]];
  assign op_idx   = op_entry[sse_pkg::SIDX_W+sse_pkg::VAL_W-1:sse_pkg::VAL_W];
  assign op_delta = op_entry[sse_pkg::VAL_W-1:0];
  assign chk_sum  = {1'b0, ram_rdata} + {1'b0, op_delta};

  assign item_addr = {mslot_q, item_q.sem_index[sse_pkg::IDX_W-1:0]};
  assign op_addr   = {mslot_q, op_idx[sse_pkg::IDX_W-1:0]};

  always_comb begin
    if (item_q.action == sse_pkg::ACT_GET_SET) begin
      hit = active_q[scan_q] && (key_q[scan_q] == item_q.key) && (item_q.key != '0);
    end else begin
      hit = active_q[scan_q] && (ident_q[scan_q] == item_q.set_id);
    end
  end

  always_comb begin
    ram_we    = cmd_i.zero_wr | cmd_i.wr_item | cmd_i.wr_op;
    ram_waddr = op_addr;
    ram_wdata = chk_sum[sse_pkg::VAL_W-1:0];
    if (cmd_i.zero_wr) begin
      ram_waddr = {fslot_q, op_q[sse_pkg::IDX_W-1:0]};
      ram_wdata = '0;
    end else if (cmd_i.wr_item) begin
      ram_waddr = item_addr;
      ram_wdata = item_q.new_value;
    end
    ram_raddr = cmd_i.rd_item ? item_addr : op_addr;
  end

  sse_ram #(
    .WIDTH (sse_pkg::VAL_W),
    .DEPTH (sse_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.alloc) begin
      key_q[fslot_q]   <= item_q.key;
      ident_q[fslot_q] <= next_ident_q;
      size_q[fslot_q]  <= item_q.count;
    end
    if (cmd_i.pend_push && (pend_cnt_q < sse_pkg::PCNT_W'(sse_pkg::SEMS_PER_SET))) begin
      pend_q[pend_cnt_q[sse_pkg::IDX_W-1:0]] <= {item_q.sem_index, item_q.sem_delta};
    end
    if (cmd_i.scan_step && !mfound_q && hit) begin
      mslot_q  <= scan_q;
      msize_q  <= size_q[scan_q];
      mident_q <= ident_q[scan_q];
    end
    if (cmd_i.scan_step && !ffound_q && !active_q[scan_q]) begin
      fslot_q <= scan_q;
    end
    if (cmd_i.val_clr) begin
      res_val_q <= '0;
    end else if (cmd_i.val_ident) begin
      res_val_q <= cmd_i.alloc ? next_ident_q : mident_q;
    end else if (cmd_i.val_ram) begin
      res_val_q <= sse_pkg::ID_W'(ram_rdata);
    end
    if (cmd_i.out_load) begin
      out_status_o <= cmd_i.out_status;
      out_wake_o   <= cmd_i.out_wake;
      out_value_o  <= (cmd_i.out_status == sse_pkg::ST_OK) ? res_val_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sse_pkg::NUM_SETS; s++) begin
        active_q[s] <= 1'b0;
      end
      next_ident_q <= sse_pkg::ID_W'(1);
      scan_q       <= '0;
      mfound_q     <= 1'b0;
      ffound_q     <= 1'b0;
      pend_cnt_q   <= '0;
      pend_ovf_q   <= 1'b0;
      pend_nw_q    <= 1'b0;
      op_q         <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.alloc) begin
        active_q[fslot_q] <= 1'b1;
        next_ident_q      <= next_ident_q + 1'b1;
      end
      if (cmd_i.remove) begin
        active_q[mslot_q] <= 1'b0;
      end
      if (cmd_i.scan_start) begin
        scan_q   <= '0;
        mfound_q <= 1'b0;
        ffound_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (hit) begin
          mfound_q <= 1'b1;
        end
        if (!active_q[scan_q]) begin
          ffound_q <= 1'b1;
        end
      end
      if (cmd_i.pend_clr) begin
        pend_cnt_q <= '0;
        pend_ovf_q <= 1'b0;
        pend_nw_q  <= 1'b0;
      end else if (cmd_i.pend_push) begin
        if (pend_cnt_q < sse_pkg::PCNT_W'(sse_pkg::SEMS_PER_SET)) begin
          pend_cnt_q <= pend_cnt_q + 1'b1;
        end else begin
          pend_ovf_q <= 1'b1;
        end
        if (item_q.no_wait) begin
          pend_nw_q <= 1'b1;
        end
      end
      if (cmd_i.op_clr) begin
        op_q <= '0;
      end else if (cmd_i.op_inc) begin
        op_q <= op_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.action         = item_q.action;
    stat_o.key_nz         = (item_q.key != '0);
    stat_o.create_flag    = item_q.create_flag;
    stat_o.exclusive_flag = item_q.exclusive_flag;
    stat_o.last_op        = item_q.last_op;
    stat_o.cnt_over       = (item_q.count > sse_pkg::COUNT_W'(sse_pkg::SEMS_PER_SET));
    stat_o.cnt_zero       = (item_q.count == '0);
    stat_o.cnt_gt_size    = (item_q.count > msize_q);
    stat_o.idx_bad        = (item_q.sem_index >= msize_q);
    stat_o.scan_last      = (scan_q == sse_pkg::SLOT_W'(sse_pkg::NUM_SETS - 1));
    stat_o.match_found    = mfound_q;
    stat_o.free_found     = ffound_q;
    stat_o.pend_over      = pend_ovf_q ||
                            (pend_cnt_q == sse_pkg::PCNT_W'(sse_pkg::SEMS_PER_SET));
    stat_o.pend_nowait    = pend_nw_q;
    stat_o.op_done        = (op_q == pend_cnt_q);
    stat_o.op_idx_bad     = (op_idx >= msize_q);
    stat_o.chk_fail       = op_delta[sse_pkg::VAL_W-1] ? !chk_sum[sse_pkg::VAL_W]
                                                        : (op_delta == '0) && (ram_rdata != '0);
    stat_o.zero_last      = (op_q[sse_pkg::IDX_W-1:0] ==
                             sse_pkg::IDX_W'(sse_pkg::SEMS_PER_SET - 1));
    stat_o.out_free       = !out_valid_o || out_ready_i;
  end
endmodule
`default_nettype wire

// ===== rtl/sse_ctrl.sv =====
// Controller state machine that sequences lookups, group checks and updates.
`timescale 1ns / 1ps
`default_nettype none
module sse_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire sse_pkg::stat_t stat_i,
  output sse_pkg::cmd_t       cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_ZERO, S_VWAIT,
    S_CHECK, S_CWAIT, S_APPLY, S_AWAIT, S_RESP
  } state_e;

  state_e                       state_q, state_d;
  logic [sse_pkg::STATUS_W-1:0] st_q, st_d;
  logic                         wake_q, wake_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    st_d    = st_q;
    wake_d  = 1'b0;
    cmd_o.out_status = st_q;
    cmd_o.out_wake   = wake_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.val_clr = 1'b1;
        state_d = S_RESP;
        st_d    = sse_pkg::ST_INVALID;
        case (stat_i.action)
          sse_pkg::ACT_GET_SET: begin
            if (!stat_i.cnt_over) begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end
          end
          sse_pkg::ACT_SEM_OP: begin
            cmd_o.pend_push = 1'b1;
            if (!stat_i.last_op) begin
              state_d = S_IDLE;
            end else if (stat_i.pend_over) begin
              cmd_o.pend_clr = 1'b1;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end
          end
          sse_pkg::ACT_GET_VALUE, sse_pkg::ACT_SET_VALUE, sse_pkg::ACT_REMOVE: begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        st_d    = sse_pkg::ST_INVALID;
        case (stat_i.action)
          sse_pkg::ACT_GET_SET: begin
            if (stat_i.key_nz && stat_i.match_found) begin
              if (stat_i.create_flag && stat_i.exclusive_flag) begin
                st_d = sse_pkg::ST_EXISTS;
              end else if (!stat_i.cnt_zero && stat_i.cnt_gt_size) begin
                st_d = sse_pkg::ST_INVALID;
              end else begin
                cmd_o.val_ident = 1'b1;
                st_d = sse_pkg::ST_OK;
              end
            end else if (stat_i.key_nz && !stat_i.create_flag) begin
              st_d = sse_pkg::ST_NOT_FOUND;
            end else if (stat_i.cnt_zero) begin
              st_d = sse_pkg::ST_INVALID;
            end else if (!stat_i.free_found) begin
              st_d = sse_pkg::ST_NO_SLOT;
            end else begin
              cmd_o.alloc     = 1'b1;
              cmd_o.val_ident = 1'b1;
              cmd_o.op_clr    = 1'b1;
              st_d    = sse_pkg::ST_OK;
              state_d = S_ZERO;
            end
          end
          sse_pkg::ACT_SEM_OP: begin
            if (!stat_i.match_found) begin
              cmd_o.pend_clr = 1'b1;
            end else begin
              cmd_o.op_clr = 1'b1;
              state_d = S_CHECK;
            end
          end
          sse_pkg::ACT_GET_VALUE: begin
            if (stat_i.match_found && !stat_i.idx_bad) begin
              cmd_o.rd_item = 1'b1;
              st_d    = sse_pkg::ST_OK;
              state_d = S_VWAIT;
            end
          end
          sse_pkg::ACT_SET_VALUE: begin
            if (stat_i.match_found && !stat_i.idx_bad) begin
              cmd_o.wr_item = 1'b1;
              st_d   = sse_pkg::ST_OK;
              wake_d = 1'b1;
            end
          end
          sse_pkg::ACT_REMOVE: begin
            if (stat_i.match_found) begin
              cmd_o.remove = 1'b1;
              st_d   = sse_pkg::ST_OK;
              wake_d = 1'b1;
            end
          end
          default: begin
            st_d = sse_pkg::ST_INVALID;
          end
        endcase
      end
      S_ZERO: begin
        cmd_o.zero_wr = 1'b1;
        cmd_o.op_inc  = 1'b1;
        if (stat_i.zero_last) begin
          state_d = S_RESP;
        end
      end
      S_VWAIT: begin
        cmd_o.val_ram = 1'b1;
        state_d = S_RESP;
      end
      S_CHECK: begin
        if (stat_i.op_done) begin
          cmd_o.op_clr = 1'b1;
          state_d = S_APPLY;
        end else if (stat_i.op_idx_bad) begin
          cmd_o.pend_clr = 1'b1;
          st_d    = sse_pkg::ST_INDEX_BIG;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_op = 1'b1;
          state_d = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (stat_i.chk_fail) begin
          cmd_o.pend_clr = 1'b1;
          st_d    = stat_i.pend_nowait ? sse_pkg::ST_WOULD_BLOCK : sse_pkg::ST_MUST_WAIT;
          state_d = S_RESP;
        end else begin
          cmd_o.op_inc = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_APPLY: begin
        if (stat_i.op_done) begin
          cmd_o.pend_clr = 1'b1;
          st_d    = sse_pkg::ST_OK;
          wake_d  = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_op = 1'b1;
          state_d = S_AWAIT;
        end
      end
      S_AWAIT: begin
        cmd_o.wr_op  = 1'b1;
        cmd_o.op_inc = 1'b1;
        state_d = S_APPLY;
      end
      S_RESP: begin
        wake_d = wake_q;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= sse_pkg::ST_OK;
      wake_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      wake_q  <= wake_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/semaphore_set_engine.sv =====
// Top level of the semaphore set engine.
`timescale 1ns / 1ps
`default_nettype none
// A table of 32 semaphore sets with 32 16-bit counters each. One request beat is taken
// at a time. Every beat except a non-final semaphore operation yields exactly one result
// beat. A lookup request scans all 32 slots in turn. An invalid action or count, or an
// overlong group, skips the scan. Get value adds a read of the counter memory, and
// creating a set clears all 32 of its counters one by one. An operation group checks and
// then updates each buffered operation, and each check and each update reads the
// counter memory through its registered read port. A non-final operation beat is only
// buffered. The next request is taken while a result beat still waits, and a request
// that finishes while the result register is still full holds until it drains.
module semaphore_set_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sse_in_if.sink     in_if,
  sse_out_if.source  out_if
);
  sse_pkg::item_t item;
  sse_pkg::cmd_t  cmd;
  sse_pkg::stat_t stat;

  always_comb begin
    item.action         = in_if.action;
    item.key            = in_if.key;
    item.count          = in_if.count;
    item.create_flag    = in_if.create_flag;
    item.exclusive_flag = in_if.exclusive_flag;
    item.set_id         = in_if.set_id;
    item.sem_index      = in_if.sem_index;
    item.sem_delta      = in_if.sem_delta;
    item.no_wait        = in_if.no_wait;
    item.last_op        = in_if.last_op;
    item.new_value      = in_if.new_value;
  end

  sse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sse_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .out_status_o (out_if.status),
    .out_value_o  (out_if.result_value),
    .out_wake_o   (out_if.wake_waiters)
  );
endmodule
`default_nettype wire

// ===== tb/tb_semaphore_set_engine.sv =====
// Self-checking testbench for the semaphore set engine with a predicting scoreboard.
`timescale 1ns / 1ps
module tb_semaphore_set_engine;
  import sse_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_BAD = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 3'd7;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     value;
    logic                wake;
  } outcome_t;

  class sem_table_scoreboard;
    bit                active [NUM_SETS];
    logic [KEY_W-1:0]  keys [NUM_SETS];
    logic [ID_W-1:0]   idents [NUM_SETS];
    int                sizes [NUM_SETS];
    logic [VAL_W-1:0]  counters [NUM_SETS][SEMS_PER_SET];
    logic [ID_W-1:0]   next_id;
    logic [ID_W-1:0]   last_new_id;
    int                op_idx [$];
    logic [VAL_W-1:0]  op_delta [$];
    bit                op_nowait;
    bit                op_overflow;
    outcome_t          expected [$];
    int                errors;
    int                checked;
    int                ok_groups;

    function new();
      foreach (active[s]) active[s] = 0;
      next_id = 1;
      last_new_id = 0;
      op_nowait = 0;
      op_overflow = 0;
      errors = 0;
      checked = 0;
      ok_groups = 0;
    endfunction

    function int slot_of(logic [ID_W-1:0] id);
      for (int s = 0; s < NUM_SETS; s++) begin
        if (active[s] && idents[s] == id) return s;
      end
      return -1;
    endfunction

    function logic [ID_W-1:0] pick_id();
      int live [$];
      for (int s = 0; s < NUM_SETS; s++) begin
        if (active[s]) live.push_back(s);
      end
      if (live.size() == 0 || $urandom_range(0, 15) == 0) return ID_W'($urandom());
      return idents[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    function int size_of(logic [ID_W-1:0] id);
      int s;
      s = slot_of(id);
      return (s < 0) ? 1 : sizes[s];
    endfunction

    function logic [STATUS_W-1:0] group_outcome(logic [ID_W-1:0] id);
      int s;
      int i;
      int v;
      s = slot_of(id);
      if (s < 0) return ST_INVALID;
      for (i = 0; i < op_idx.size(); i++) begin
        if (op_idx[i] >= sizes[s]) return ST_INDEX_BIG;
        v = int'(counters[s][op_idx[i]]);
        if (op_delta[i][VAL_W-1]) begin
          if (v < 32'h10000 - op_delta[i]) break;
        end else if (op_delta[i] == 0) begin
          if (v != 0) break;
        end
      end
      if (i < op_idx.size()) return op_nowait ? ST_WOULD_BLOCK : ST_MUST_WAIT;
      for (i = 0; i < op_idx.size(); i++) begin
        counters[s][op_idx[i]] = counters[s][op_idx[i]] + op_delta[i];
      end
      return ST_OK;
    endfunction

    function outcome_t lookup_or_create(item_t it);
      outcome_t r;
      int f;
      r = '0;
      r.status = ST_INVALID;
      if (it.count > SEMS_PER_SET) return r;
      if (it.key != 0) begin
        for (int s = 0; s < NUM_SETS; s++) begin
          if (active[s] && keys[s] == it.key) begin
            if (it.create_flag && it.exclusive_flag) r.status = ST_EXISTS;
            else if (it.count != 0 && it.count > sizes[s]) r.status = ST_INVALID;
            else begin
              r.status = ST_OK;
              r.value = idents[s];
            end
            return r;
          end
        end
        if (!it.create_flag) begin
          r.status = ST_NOT_FOUND;
          return r;
        end
      end
      if (it.count == 0) return r;
      f = -1;
      for (int s = NUM_SETS - 1; s >= 0; s--) begin
        if (!active[s]) f = s;
      end
      if (f < 0) begin
        r.status = ST_NO_SLOT;
        return r;
      end
      active[f] = 1;
      keys[f] = it.key;
      sizes[f] = int'(it.count);
      idents[f] = next_id;
      last_new_id = next_id;
      next_id = next_id + 1'b1;
      for (int i = 0; i < SEMS_PER_SET; i++) counters[f][i] = '0;
      r.status = ST_OK;
      r.value = idents[f];
      return r;
    endfunction

    function void note_request(item_t it);
      outcome_t r;
      int s;
      r = '0;
      case (it.action)
        ACT_GET_SET: r = lookup_or_create(it);
        ACT_SEM_OP: begin
          if (op_idx.size() < SEMS_PER_SET) begin
            op_idx.push_back(int'(it.sem_index));
            op_delta.push_back(it.sem_delta);
          end else begin
            op_overflow = 1;
          end
          if (it.no_wait) op_nowait = 1;
          if (!it.last_op) return;
          r.status = op_overflow ? ST_INVALID : group_outcome(it.set_id);
          r.wake = (r.status == ST_OK);
          if (r.wake) ok_groups++;
          op_idx.delete();
          op_delta.delete();
          op_nowait = 0;
          op_overflow = 0;
        end
        ACT_GET_VALUE, ACT_SET_VALUE: begin
          s = slot_of(it.set_id);
          if (s < 0 || it.sem_index >= sizes[s]) r.status = ST_INVALID;
          else if (it.action == ACT_GET_VALUE) begin
            r.status = ST_OK;
            r.value = ID_W'(counters[s][it.sem_index]);
          end else begin
            counters[s][it.sem_index] = it.new_value;
            r.status = ST_OK;
            r.wake = 1;
          end
        end
        ACT_REMOVE: begin
          s = slot_of(it.set_id);
          if (s < 0) r.status = ST_INVALID;
          else begin
            active[s] = 0;
            r.status = ST_OK;
            r.wake = 1;
          end
        end
        default: r.status = ST_INVALID;
      endcase
      expected.push_back(r);
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp;
      checked++;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d value %0d wake %0d",
                 $realtime, got.status, got.value, got.wake);
        return;
      end
      exp = expected.pop_front();
      if (got.status !== exp.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $realtime, exp.status,
                 got.status);
      end
      if (got.value !== exp.value) begin
        errors++;
        $display("%0t: result_value mismatch: expected %0d, actual %0d", $realtime,
                 exp.value, got.value);
      end
      if (got.wake !== exp.wake) begin
        errors++;
        $display("%0t: wake_waiters mismatch: expected %0d, actual %0d", $realtime,
                 exp.wake, got.wake);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  sse_in_if  in_bus ();
  sse_out_if out_bus ();

  semaphore_set_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus.sink),
    .out_if (out_bus.source)
  );

  sem_table_scoreboard sb;
  bit quiet;
  int n_sent;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off, and a check on every beat.
  initial begin
    int stall_left;
    int n_edges;
    stall_left = 0;
    n_edges = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n_edges++;
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result('{out_bus.status, out_bus.result_value, out_bus.wake_waiters});
      end
      if (n_edges == 3000) stall_left = 1500;
      else if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
      out_bus.ready <= (stall_left == 0);
    end
  end

  task automatic send(item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.action <= it.action;
    in_bus.key <= it.key;
    in_bus.count <= it.count;
    in_bus.create_flag <= it.create_flag;
    in_bus.exclusive_flag <= it.exclusive_flag;
    in_bus.set_id <= it.set_id;
    in_bus.sem_index <= it.sem_index;
    in_bus.sem_delta <= it.sem_delta;
    in_bus.no_wait <= it.no_wait;
    in_bus.last_op <= it.last_op;
    in_bus.new_value <= it.new_value;
    in_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_request(it);
    n_sent++;
  endtask

  function automatic item_t noise_item(logic [ACTION_W-1:0] act);
    item_t it;
    it = item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.action = act;
    return it;
  endfunction

  function automatic item_t get_set(logic [KEY_W-1:0] k, int cnt, bit cr, bit ex);
    item_t it;
    it = noise_item(ACT_GET_SET);
    it.key = k;
    it.count = COUNT_W'(cnt);
    it.create_flag = cr;
    it.exclusive_flag = ex;
    return it;
  endfunction

  function automatic item_t value_item(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                       int idx, logic [VAL_W-1:0] nv);
    item_t it;
    it = noise_item(act);
    it.set_id = id;
    it.sem_index = SIDX_W'(idx);
    it.new_value = nv;
    return it;
  endfunction

  function automatic item_t op_item(logic [ID_W-1:0] id, int idx, logic [VAL_W-1:0] d,
                                    bit nw, bit last);
    item_t it;
    it = noise_item(ACT_SEM_OP);
    it.set_id = id;
    it.sem_index = SIDX_W'(idx);
    it.sem_delta = d;
    it.no_wait = nw;
    it.last_op = last;
    return it;
  endfunction

  task automatic random_group(int len);
    logic [ID_W-1:0] id;
    int sz;
    int idx;
    logic [VAL_W-1:0] d;
    id = sb.pick_id();
    sz = sb.size_of(id);
    for (int i = 0; i < len; i++) begin
      idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, sz - 1);
      case ($urandom_range(0, 5))
        0: d = '0;
        1: d = VAL_W'($urandom());
        2, 3: d = VAL_W'(-$urandom_range(1, 4));
        default: d = VAL_W'($urandom_range(1, 6));
      endcase
      send(op_item(id, idx, d, $urandom_range(0, 3) == 0, i == len - 1));
    end
  endtask

  initial begin
    logic [ID_W-1:0] id;
    int len;
    sb = new();
    quiet = 0;
    n_sent = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_GET_SET;
    in_bus.key <= '0;
    in_bus.count <= '0;
    in_bus.create_flag <= 1'b0;
    in_bus.exclusive_flag <= 1'b0;
    in_bus.set_id <= '0;
    in_bus.sem_index <= '0;
    in_bus.sem_delta <= '0;
    in_bus.no_wait <= 1'b0;
    in_bus.last_op <= 1'b0;
    in_bus.new_value <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(get_set('0, SEMS_PER_SET, 1, 0));
    send(get_set(32'hFFFF_FFFF, 3, 1, 0));
    id = sb.last_new_id;
    send(get_set(32'hFFFF_FFFF, 3, 1, 1));
    send(get_set(32'hFFFF_FFFF, 5, 0, 0));
    send(get_set(32'hFFFF_FFFF, 0, 0, 0));
    send(get_set(32'h1234_5678, 2, 0, 0));
    send(get_set(32'h55, SEMS_PER_SET + 1, 1, 0));
    send(get_set(32'h55, 63, 1, 0));
    send(get_set(32'h55, 0, 1, 0));
    send(op_item(id, 0, 16'd5, 0, 0));
    send(op_item(id, 0, 16'hFFFD, 0, 1));
    send(value_item(ACT_GET_VALUE, id, 0, '0));
    send(op_item(id, 0, 16'hFFF9, 1, 1));
    send(op_item(id, 0, 16'h0000, 0, 1));
    send(op_item(id, 40, 16'd1, 0, 1));
    send(op_item(~id, 1, 16'd1, 0, 1));
    send(value_item(ACT_SET_VALUE, id, 2, 16'hFFFF));
    send(op_item(id, 2, 16'd1, 0, 1));
    send(value_item(ACT_GET_VALUE, id, 2, '0));
    send(op_item(id, 1, 16'h8000, 0, 1));
    send(value_item(ACT_GET_VALUE, id, 63, '0));
    send(noise_item(ACT_BAD));
    send(noise_item(ACT_RESERVED));
    send(value_item(ACT_REMOVE, id, 0, '0));
    send(value_item(ACT_REMOVE, id, 0, '0));

    while (n_sent < RANDOM_ITEMS + 25) begin
      if (n_sent > RANDOM_ITEMS - 50) quiet = 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: send(get_set(($urandom_range(0, 7) == 0) ? $urandom() :
                                 $urandom_range(0, 40), $urandom_range(0, 9) == 0 ?
                                 $urandom_range(0, 63) : $urandom_range(1, 6),
                                 $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1))));
        4, 5, 6, 7, 8: begin
          len = ($urandom_range(0, 60) == 0) ? SEMS_PER_SET + $urandom_range(0, 2) :
                $urandom_range(1, 4);
          random_group(len);
        end
        9, 10, 11: begin
          id = sb.pick_id();
          send(value_item(ACT_GET_VALUE, id, ($urandom_range(0, 9) == 0) ?
               $urandom_range(0, 63) : $urandom_range(0, sb.size_of(id) - 1), '0));
        end
        12, 13: begin
          id = sb.pick_id();
          send(value_item(ACT_SET_VALUE, id, ($urandom_range(0, 9) == 0) ?
               $urandom_range(0, 63) : $urandom_range(0, sb.size_of(id) - 1),
               ($urandom_range(0, 1) == 0) ? VAL_W'($urandom()) :
                                              VAL_W'($urandom_range(0, 5))));
        end
        14: send(value_item(ACT_REMOVE, sb.pick_id(), 0, '0));
        15: if (n_sent > RANDOM_ITEMS / 2) send(value_item(ACT_REMOVE, sb.pick_id(), 0, '0));
        16: send(noise_item(ACTION_W'(ACT_BAD + $urandom_range(0, 2))));
        default: send(op_item(sb.pick_id(), $urandom_range(0, 63), VAL_W'($urandom()),
                              1'($urandom_range(0, 1)), 1));
      endcase
    end
    in_bus.valid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d request beats and checked %0d result beats.", n_sent, sb.checked);
    $display("Covered set lookup and creation, %0d successful operation groups, value access,",
             sb.ok_groups);
    $display("removal and invalid requests under random and long result stalls.");
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
